// ----- hdl/mcstb_pkg.sv -----
// Shared types and constants for the soft timer bank.
// Depends on nothing; used by the interfaces, the timer ALU and the core.
package mcstb_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int VALUE_W        = 32;
    localparam int INDEX_W        = 4;

    typedef enum logic [2:0] {
        ACT_ALLOC      = 3'd0,
        ACT_READ_CLEAR = 3'd1,
        ACT_READ_PER   = 3'd2,
        ACT_READ_CNT   = 3'd3,
        ACT_SET_PER    = 3'd4,
        ACT_DISABLE    = 3'd5,
        ACT_ENABLE     = 3'd6,
        ACT_TICK       = 3'd7
    } action_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [INDEX_W-1:0] timer_index;
        logic [VALUE_W-1:0] value;
        logic               periodic;
    } req_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic               flag_was_set;
        logic               any_expired;
        logic [INDEX_W-1:0] expired_index;
        logic               alloc_failed;
    } rsp_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0] count;
        logic               expired;
    } alu_res_t;

endpackage

// ----- hdl/mcstb_req_if.sv -----
// Request channel: valid/ready handshake carrying one request word.
// Depends on mcstb_pkg.
interface mcstb_req_if;
    logic                  valid;
    logic                  ready;
    mcstb_pkg::req_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/mcstb_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one result word.
// Depends on mcstb_pkg.
interface mcstb_rsp_if;
    logic                  valid;
    logic                  ready;
    mcstb_pkg::rsp_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/mcstb_timer_alu.sv -----
// Shared per-timer update unit: active test, decrement, expiry and reload.
// Depends on mcstb_pkg.
module mcstb_timer_alu
(
    input  logic [mcstb_pkg::VALUE_W-1:0] count,
    input  logic [mcstb_pkg::VALUE_W-1:0] period,
    input  logic                          mode,
    output mcstb_pkg::alu_res_t           res
);

    logic                          active;
    logic [mcstb_pkg::VALUE_W-1:0] dec;

    assign active = (count != '0) && (count <= period);
    assign dec    = count - mcstb_pkg::VALUE_W'(1);

    always_comb
    begin
        res.expired = active && (dec == '0);
        if (res.expired)
        begin
            res.count = mode ? period : '0;
        end
        else if (active)
        begin
            res.count = dec;
        end
        else
        begin
            res.count = count;
        end
    end

endmodule

// ----- hdl/multi_channel_soft_timer_bank_core.sv -----
// Soft timer bank top level: request decode, timer stores, tick walker, result register.
// Depends on mcstb_pkg, mcstb_req_if, mcstb_rsp_if and mcstb_timer_alu.
//
//  channel | dir | word                                         | handshake
//  req     | in  | action, timer_index, value, periodic         | valid/ready
//  rsp     | out | read_value, flag_was_set, any_expired,       | valid/ready
//          |     | expired_index, alloc_failed                  |
//
// Non-tick words: accepted in S_IDLE, executed in S_EXEC; the result is registered from S_EXEC.
// Tick: accepted in S_IDLE, then S_WALK visits timers 0 up to highest_reg (the highest allocated index,
// 0 after reset), one timer per cycle through the single shared timer ALU.
// One word in flight; req.ready is high in idle while the result register is empty
// or being drained. A stalled rsp holds its word and blocks the next request.
// Reset is asynchronous and clears all timer state; no clearing pass.
module multi_channel_soft_timer_bank_core
#(
    parameter int NUM_TIMERS = mcstb_pkg::NUM_TIMERS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    mcstb_req_if.sink          req,
    mcstb_rsp_if.source        rsp
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);
    localparam int VW    = mcstb_pkg::VALUE_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_WALK = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    mcstb_pkg::req_word_t  op_reg;
    logic [CNT_W-1:0]      next_free_reg, next_free_next;
    logic [IDX_W-1:0]      highest_reg, highest_next;
    logic [IDX_W-1:0]      walk_idx_reg, walk_idx_next;
    logic                  any_reg, any_next;
    logic [IDX_W-1:0]      xidx_reg, xidx_next;
    logic                  out_valid_reg, out_valid_next;
    mcstb_pkg::rsp_word_t  out_reg, out_next;

    logic [VW-1:0]         period_reg [NUM_TIMERS];
    logic [VW-1:0]         count_reg  [NUM_TIMERS];
    logic                  mode_reg   [NUM_TIMERS];
    logic                  flag_reg   [NUM_TIMERS];

    logic                  req_fire;
    logic                  idx_ok;
    logic                  bank_free;
    logic [IDX_W-1:0]      ix;
    logic [IDX_W-1:0]      nf_ix;
    mcstb_pkg::action_t    act;
    mcstb_pkg::alu_res_t   alu_res;
    mcstb_pkg::rsp_word_t  exec_res;

    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign req_fire  = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    assign act       = mcstb_pkg::action_t'(op_reg.action);
    assign idx_ok    = 32'(op_reg.timer_index) < 32'(NUM_TIMERS);
    assign bank_free = 32'(next_free_reg) < 32'(NUM_TIMERS);
    assign ix        = IDX_W'(op_reg.timer_index);
    assign nf_ix     = IDX_W'(next_free_reg);

    mcstb_timer_alu u_alu
    (
        .count  (count_reg[walk_idx_reg]),
        .period (period_reg[walk_idx_reg]),
        .mode   (mode_reg[walk_idx_reg]),
        .res    (alu_res)
    );

    always_comb
    begin
        exec_res = '0;
        case (act)
            mcstb_pkg::ACT_ALLOC:
            begin
                if (bank_free)
                begin
                    exec_res.read_value = VW'(next_free_reg);
                end
                else
                begin
                    exec_res.alloc_failed = 1'b1;
                end
            end
            mcstb_pkg::ACT_READ_CLEAR:
            begin
                exec_res.flag_was_set = idx_ok && flag_reg[ix];
            end
            mcstb_pkg::ACT_READ_PER:
            begin
                if (idx_ok)
                begin
                    exec_res.read_value = period_reg[ix];
                end
            end
            mcstb_pkg::ACT_READ_CNT:
            begin
                if (idx_ok)
                begin
                    exec_res.read_value = count_reg[ix];
                end
            end
            default:
            begin
                exec_res = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        next_free_next = next_free_reg;
        highest_next   = highest_reg;
        walk_idx_next  = walk_idx_reg;
        any_next       = any_reg;
        xidx_next      = xidx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    walk_idx_next = '0;
                    any_next      = 1'b0;
                    xidx_next     = '0;
                    if (mcstb_pkg::action_t'(req.data.action) == mcstb_pkg::ACT_TICK)
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                if ((act == mcstb_pkg::ACT_ALLOC) && bank_free)
                begin
                    highest_next   = nf_ix;
                    next_free_next = next_free_reg + CNT_W'(1);
                end
                out_next       = exec_res;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_WALK:
            begin
                if (alu_res.expired)
                begin
                    any_next  = 1'b1;
                    xidx_next = walk_idx_reg;
                end
                if (walk_idx_reg == highest_reg)
                begin
                    out_next               = '0;
                    out_next.any_expired   = any_next;
                    out_next.expired_index = mcstb_pkg::INDEX_W'(xidx_next);
                    out_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
                else
                begin
                    walk_idx_next = walk_idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            next_free_reg <= '0;
            highest_reg   <= '0;
            walk_idx_reg  <= '0;
            any_reg       <= 1'b0;
            xidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            highest_reg   <= highest_next;
            walk_idx_reg  <= walk_idx_next;
            any_reg       <= any_next;
            xidx_reg      <= xidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (req_fire)
        begin
            op_reg <= req.data;
        end
    end

    // timer stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                period_reg[i] <= '0;
                count_reg[i]  <= '0;
                mode_reg[i]   <= 1'b0;
                flag_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                S_EXEC:
                begin
                    case (act)
                        mcstb_pkg::ACT_ALLOC:
                        begin
                            if (bank_free)
                            begin
                                period_reg[nf_ix] <= op_reg.value;
                                count_reg[nf_ix]  <= op_reg.value;
                                mode_reg[nf_ix]   <= op_reg.periodic;
                                flag_reg[nf_ix]   <= 1'b0;
                            end
                        end
                        mcstb_pkg::ACT_READ_CLEAR:
                        begin
                            if (idx_ok)
                            begin
                                flag_reg[ix] <= 1'b0;
                            end
                        end
                        mcstb_pkg::ACT_SET_PER:
                        begin
                            if (idx_ok)
                            begin
                                period_reg[ix] <= op_reg.value;
                                count_reg[ix]  <= '0;
                            end
                        end
                        mcstb_pkg::ACT_DISABLE:
                        begin
                            if (idx_ok)
                            begin
                                count_reg[ix] <= '0;
                            end
                        end
                        mcstb_pkg::ACT_ENABLE:
                        begin
                            if (idx_ok)
                            begin
                                count_reg[ix] <= (op_reg.value != '0) ? op_reg.value
                                                                      : period_reg[ix];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_WALK:
                begin
                    count_reg[walk_idx_reg] <= alu_res.count;
                    if (alu_res.expired)
                    begin
                        flag_reg[walk_idx_reg] <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

`ifndef SYNTH
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (walk_idx_reg <= highest_reg))
        else $error("tick walk index past highest allocated timer");

    a_alloc_order: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg == '0) || (32'(highest_reg) < 32'(next_free_reg)))
        else $error("highest allocated index not below next free slot");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(next_free_reg) <= 32'(NUM_TIMERS))
        else $error("next free slot beyond bank");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> ((state_reg == S_EXEC) || (state_reg == S_WALK)))
        else $error("accepted word did not start work");

    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past((state_reg == S_EXEC) || (state_reg == S_WALK)))
        else $error("result raised outside of work completion");
`endif

endmodule

// ----- tb/sv/multi_channel_soft_timer_bank_core_test.sv -----
// Self-checking bench for the soft timer bank: directed table, then random op sequences.
// Typed rows match their table word; others an in-bench model of timer stores and tick walk.
// Depends on mcstb_pkg, mcstb_req_if, mcstb_rsp_if and multi_channel_soft_timer_bank_core.
module multi_channel_soft_timer_bank_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_T        = mcstb_pkg::NUM_TIMERS_DEF;
    localparam int RANDOM_WORDS = 1650;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2 * NUM_T + 8;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct {
        mcstb_pkg::req_word_t w;
        bit                   typed;
        mcstb_pkg::rsp_word_t want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    mcstb_req_if req_ch();
    mcstb_rsp_if rsp_ch();

    multi_channel_soft_timer_bank_core #(.NUM_TIMERS(NUM_T)) u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // model of the timer stores
    logic [31:0] per_mem  [NUM_T] = '{default: '0};
    logic [31:0] cnt_mem  [NUM_T] = '{default: '0};
    logic        mode_mem [NUM_T] = '{default: 1'b0};
    logic        flag_mem [NUM_T] = '{default: 1'b0};
    int unsigned next_slot = 0;
    int unsigned top_slot  = 0;

    mcstb_pkg::rsp_word_t pending_rsp[$];
    plan_row_t            plan[$];
    int                   n_errors   = 0;
    int                   words_sent = 0;
    int                   cycle_cnt  = 0;
    int                   hold_asks  = 0;
    bit                   steady     = 1'b0;

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAIL multi_channel_soft_timer_bank_core");
            $finish;
        end
    end

    function automatic mcstb_pkg::rsp_word_t bank_step(input mcstb_pkg::req_word_t w);
        mcstb_pkg::rsp_word_t r;
        int unsigned          n;
        bit                   ok;
        r  = '0;
        ok = int'(w.timer_index) < NUM_T;
        case (w.action)
            mcstb_pkg::ACT_ALLOC:
            begin
                if (next_slot < NUM_T)
                begin
                    n           = next_slot;
                    per_mem[n]  = w.value;
                    cnt_mem[n]  = w.value;
                    mode_mem[n] = w.periodic;
                    flag_mem[n] = 1'b0;
                    top_slot    = n;
                    next_slot   = n + 1;
                    r.read_value = 32'(n);
                end
                else
                begin
                    r.alloc_failed = 1'b1;
                end
            end
            mcstb_pkg::ACT_READ_CLEAR:
            begin
                if (ok && flag_mem[w.timer_index])
                begin
                    flag_mem[w.timer_index] = 1'b0;
                    r.flag_was_set          = 1'b1;
                end
            end
            mcstb_pkg::ACT_READ_PER:
            begin
                if (ok)
                    r.read_value = per_mem[w.timer_index];
            end
            mcstb_pkg::ACT_READ_CNT:
            begin
                if (ok)
                    r.read_value = cnt_mem[w.timer_index];
            end
            mcstb_pkg::ACT_SET_PER:
            begin
                if (ok)
                begin
                    per_mem[w.timer_index] = w.value;
                    cnt_mem[w.timer_index] = '0;
                end
            end
            mcstb_pkg::ACT_DISABLE:
            begin
                if (ok)
                    cnt_mem[w.timer_index] = '0;
            end
            mcstb_pkg::ACT_ENABLE:
            begin
                if (ok)
                    cnt_mem[w.timer_index] = (w.value != '0) ? w.value : per_mem[w.timer_index];
            end
            default:
            begin
                for (int i = 0; i <= int'(top_slot) && i < NUM_T; i++)
                begin
                    if (cnt_mem[i] != '0 && cnt_mem[i] <= per_mem[i])
                    begin
                        cnt_mem[i] = cnt_mem[i] - 32'd1;
                        if (cnt_mem[i] == '0)
                        begin
                            r.any_expired   = 1'b1;
                            r.expired_index = 4'(i);
                            flag_mem[i]     = 1'b1;
                            if (mode_mem[i])
                                cnt_mem[i] = per_mem[i];
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, seen, want, cycle_cnt);
        n_errors++;
    endtask

    // result checker
    mcstb_pkg::rsp_word_t want_rsp;
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                flag_mismatch("unexpected word", 32'(rsp_ch.data), '0);
            end
            else
            begin
                want_rsp = pending_rsp.pop_front();
                if (rsp_ch.data.read_value !== want_rsp.read_value)
                    flag_mismatch("read_value", rsp_ch.data.read_value, want_rsp.read_value);
                if (rsp_ch.data.flag_was_set !== want_rsp.flag_was_set)
                    flag_mismatch("flag_was_set", 32'(rsp_ch.data.flag_was_set),
                                  32'(want_rsp.flag_was_set));
                if (rsp_ch.data.any_expired !== want_rsp.any_expired)
                    flag_mismatch("any_expired", 32'(rsp_ch.data.any_expired),
                                  32'(want_rsp.any_expired));
                if (rsp_ch.data.expired_index !== want_rsp.expired_index)
                    flag_mismatch("expired_index", 32'(rsp_ch.data.expired_index),
                                  32'(want_rsp.expired_index));
                if (rsp_ch.data.alloc_failed !== want_rsp.alloc_failed)
                    flag_mismatch("alloc_failed", 32'(rsp_ch.data.alloc_failed),
                                  32'(want_rsp.alloc_failed));
            end
        end
    end

    // result side: random stalls, long hold-offs on request
    initial
    begin
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_asks > holds_done)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (steady)
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= ($urandom_range(99) >= 30);
        end
    end

    task automatic send_word(input mcstb_pkg::req_word_t w, input bit typed,
                             input mcstb_pkg::rsp_word_t want);
        mcstb_pkg::rsp_word_t pred;
        @(negedge clk);
        while (!steady && $urandom_range(99) < 30)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pred = bank_step(w);
        pending_rsp.push_back(typed ? want : pred);
        words_sent++;
    endtask

    task automatic send_op(input mcstb_pkg::action_t a, input logic [3:0] ix,
                           input logic [31:0] v, input logic p);
        mcstb_pkg::req_word_t w;
        w.action      = a;
        w.timer_index = ix;
        w.value       = v;
        w.periodic    = p;
        send_word(w, 1'b0, '0);
    endtask

    function automatic plan_row_t plan_row(input mcstb_pkg::action_t a, input logic [3:0] ix,
                                           input logic [31:0] v, input logic p,
                                           input bit typed = 1'b0,
                                           input logic [31:0] rd = '0,
                                           input logic fl = 1'b0, input logic an = 1'b0,
                                           input logic [3:0] xi = '0,
                                           input logic fa = 1'b0);
        plan_row_t r;
        r.w.action           = a;
        r.w.timer_index      = ix;
        r.w.value            = v;
        r.w.periodic         = p;
        r.typed              = typed;
        r.want.read_value    = rd;
        r.want.flag_was_set  = fl;
        r.want.any_expired   = an;
        r.want.expired_index = xi;
        r.want.alloc_failed  = fa;
        return r;
    endfunction

    task automatic random_burst();
        mcstb_pkg::req_word_t w;
        int                   pick;
        int                   n_ticks;
        logic [3:0]           ix;
        logic [31:0]          per;
        logic [31:0]          start;
        pick = $urandom_range(99);
        ix   = 4'($urandom_range(NUM_T - 1));
        if (pick < 60)
        begin
            // arm one timer, run it, then look at it
            per = ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(6));
            send_op(mcstb_pkg::ACT_SET_PER, ix, per, 1'($urandom_range(1)));
            case ($urandom_range(3))
                0:       start = '0;
                1:       start = per;
                2:       start = (per < 32'd16) ? 32'($urandom_range(per)) : 32'($urandom);
                default: start = per + 32'd1;
            endcase
            send_op(mcstb_pkg::ACT_ENABLE, ix, start, 1'($urandom_range(1)));
            n_ticks = $urandom_range(1, 8);
            repeat (n_ticks)
                send_op(mcstb_pkg::ACT_TICK, 4'($urandom), 32'($urandom),
                        1'($urandom_range(1)));
            send_op(mcstb_pkg::ACT_READ_CLEAR, ix, 32'($urandom), 1'($urandom_range(1)));
            send_op(mcstb_pkg::ACT_READ_CNT, ix, 32'($urandom), 1'($urandom_range(1)));
            if ($urandom_range(3) == 0)
                send_op(mcstb_pkg::ACT_READ_PER, ix, 32'($urandom), 1'($urandom_range(1)));
        end
        else if (pick < 85)
        begin
            w.action      = 3'($urandom);
            w.timer_index = 4'($urandom);
            w.value       = 32'($urandom);
            w.periodic    = 1'($urandom_range(1));
            send_word(w, 1'b0, '0);
        end
        else
        begin
            // stop a timer mid-run and keep ticking
            send_op(mcstb_pkg::ACT_DISABLE, ix, 32'($urandom), 1'($urandom_range(1)));
            n_ticks = $urandom_range(1, 3);
            repeat (n_ticks)
                send_op(mcstb_pkg::ACT_TICK, 4'($urandom), 32'($urandom),
                        1'($urandom_range(1)));
            send_op(mcstb_pkg::ACT_READ_CNT, ix, 32'($urandom), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        int rnd;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;

        // typed rows: reset state, allocation numbers, extremes, bank full
        plan.push_back(plan_row(mcstb_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0, 1'b1));
        plan.push_back(plan_row(mcstb_pkg::ACT_READ_CNT, 4'd15, 32'hFFFF_FFFF, 1'b1,
                                1'b1, 32'd0));
        plan.push_back(plan_row(mcstb_pkg::ACT_ALLOC, 4'd9, 32'd2, 1'b1, 1'b1, 32'd0));
        plan.push_back(plan_row(mcstb_pkg::ACT_ALLOC, 4'd0, 32'hFFFF_FFFF, 1'b0,
                                1'b1, 32'd1));
        plan.push_back(plan_row(mcstb_pkg::ACT_READ_PER, 4'd1, 32'd0, 1'b0,
                                1'b1, 32'hFFFF_FFFF));
        plan.push_back(plan_row(mcstb_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0));
        plan.push_back(plan_row(mcstb_pkg::ACT_TICK, 4'd15, 32'hFFFF_FFFF, 1'b1));
        plan.push_back(plan_row(mcstb_pkg::ACT_READ_CLEAR, 4'd0, 32'd0, 1'b0));
        plan.push_back(plan_row(mcstb_pkg::ACT_READ_CLEAR, 4'd0, 32'd0, 1'b0));
        plan.push_back(plan_row(mcstb_pkg::ACT_ENABLE, 4'd1, 32'd1, 1'b0));
        plan.push_back(plan_row(mcstb_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0));
        // count above period: timer 0 must stay put
        plan.push_back(plan_row(mcstb_pkg::ACT_ENABLE, 4'd0, 32'h8000_0000, 1'b0));
        plan.push_back(plan_row(mcstb_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0));
        plan.push_back(plan_row(mcstb_pkg::ACT_READ_CNT, 4'd0, 32'd0, 1'b0));
        plan.push_back(plan_row(mcstb_pkg::ACT_SET_PER, 4'd0, 32'd0, 1'b1));
        plan.push_back(plan_row(mcstb_pkg::ACT_ENABLE, 4'd0, 32'd0, 1'b0));
        plan.push_back(plan_row(mcstb_pkg::ACT_DISABLE, 4'd1, 32'hFFFF_FFFF, 1'b1));
        for (int i = 2; i < NUM_T; i++)
            plan.push_back(plan_row(mcstb_pkg::ACT_ALLOC, 4'(i),
                                    (i == 2) ? 32'd0 :
                                    (i == 3) ? 32'h8000_0000 :
                                    (i == NUM_T - 1) ? 32'hFFFF_FFFF : 32'(1 + i % 5),
                                    1'(i % 2), 1'b1, 32'(i)));
        plan.push_back(plan_row(mcstb_pkg::ACT_ALLOC, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b1,
                                32'd0, 1'b0, 1'b0, 4'd0, 1'b1));
        plan.push_back(plan_row(mcstb_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[k])
            send_word(plan[k].w, plan[k].typed, plan[k].want);

        while (words_sent < plan.size() + RANDOM_WORDS)
        begin
            rnd    = words_sent - plan.size();
            steady = (rnd >= 600 && rnd < 900);
            if ((rnd >= 200 && hold_asks == 0) || (rnd >= 1200 && hold_asks == 1))
                hold_asks++;
            random_burst();
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        steady = 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_errors == 0)
        begin
            $display("PASS multi_channel_soft_timer_bank_core");
        end
        else
        begin
            $display("FAIL multi_channel_soft_timer_bank_core");
        end
        $finish;
    end

endmodule
